// ===== rtl/core/rida_pkg.sv =====
// ============================================================================
// Ranged ID allocator package
// Shared constants, codes, types and helper functions for the ID allocator.
// ============================================================================
`default_nettype none

package rida_pkg;

  // Size of the ID space and of one bitmap word.
  localparam int ID_SPACE  = 65536;
  localparam int WORD_BITS = 64;
  localparam int MAP_WORDS = ID_SPACE / WORD_BITS;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int ID_W      = 16;
  localparam int CFG_IDX_W = 3;

  // Highest ID that the bitmap can hold, limited to what an ID field can carry.
  localparam int ID_LIM = (ID_SPACE > (1 << ID_W)) ? ((1 << ID_W) - 1) : (ID_SPACE - 1);
  localparam logic [ID_W-1:0] ID_MAX = ID_W'(ID_LIM);
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);

  typedef enum logic [1:0] {
    OP_AUTO = 2'd0,
    OP_SPEC = 2'd1,
    OP_KERN = 2'd2,
    OP_FREE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_TAKEN   = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_RESERVED_TOP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USER_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ID_TOP        = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RMW,
    S_RANGE,
    S_SCAN,
    S_HOLD
  } ctrl_state_t;

  typedef struct packed {
    logic [ID_W-1:0] reserved_top;
    logic [ID_W-1:0] overflow_low;
    logic [ID_W-1:0] overflow_high;
    logic [ID_W-1:0] user_low;
    logic [ID_W-1:0] id_top;
  } cfg_t;

  typedef struct packed {
    logic                 en;
    logic                 we;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] id;
  } result_t;

  function automatic logic [ADDR_W-1:0] word_of(input logic [ID_W-1:0] id);
    return ADDR_W'(id >> BIT_W);
  endfunction

  // Lowest set bit of a word: {found, index}.
  function automatic logic [BIT_W:0] first_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, BIT_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rida_map_mem.sv =====
// ============================================================================
// Ranged ID allocator bitmap memory
// Single-port synchronous RAM holding the use bitmap, with a registered read.
// ============================================================================
`default_nettype none

module rida_map_mem (
  input  wire logic                          clk,
  input  wire rida_pkg::mem_req_t            req,
  output logic [rida_pkg::WORD_BITS-1:0]     rdata
);
  import rida_pkg::*;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rida_ctrl.sv =====
// ============================================================================
// Ranged ID allocator controller
// Sequencer for the clearing pass, single-ID read-modify-write and range scans.
// ============================================================================
`default_nettype none

module rida_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rida_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    in_op,
  input  wire logic [rida_pkg::ID_W-1:0]     in_tid,
  output logic                               res_valid,
  input  wire logic                          res_take,
  output rida_pkg::result_t                  res,
  output rida_pkg::mem_req_t                 mem_req,
  input  wire logic [rida_pkg::WORD_BITS-1:0] mem_rdata
);
  import rida_pkg::*;

  ctrl_state_t          state_r, state_nxt;
  logic [ADDR_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  op_t                  op_r, op_nxt;
  logic [ID_W-1:0]      tid_r, tid_nxt;
  logic                 range2_r, range2_nxt;
  logic [ID_W-1:0]      lo_r, lo_nxt;
  logic [ID_W-1:0]      hi_r, hi_nxt;
  logic [ADDR_W-1:0]    iss_w_r, iss_w_nxt;
  logic                 iss_done_r, iss_done_nxt;
  logic                 dv_r, dv_nxt;
  logic [ADDR_W-1:0]    dw_r, dw_nxt;
  result_t              res_r, res_nxt;

  logic [ID_W-1:0]      top;
  logic [ID_W-1:0]      ovf_hi;
  logic [ID_W-1:0]      rng_lo;
  logic [ID_W-1:0]      rng_hi;
  logic                 rng_empty;
  logic [ADDR_W-1:0]    lo_w;
  logic [ADDR_W-1:0]    hi_w;
  logic [BIT_W-1:0]     lo_b;
  logic [BIT_W-1:0]     hi_b;
  logic [WORD_BITS-1:0] free_bits;
  logic [BIT_W:0]       hit;
  logic                 found;
  logic                 cur_bit;
  logic                 spec_bad;
  logic                 kern_bad;
  logic                 free_bad;

  // Effective top and the clamped fallback range.
  assign top    = (cfg.id_top > ID_MAX) ? ID_MAX : cfg.id_top;
  assign ovf_hi = (cfg.overflow_high > top) ? top : cfg.overflow_high;
  assign rng_lo = range2_r ? cfg.overflow_low : cfg.user_low;
  assign rng_hi = range2_r ? ovf_hi : top;
  assign rng_empty = rng_lo > rng_hi;

  assign lo_w = word_of(lo_r);
  assign hi_w = word_of(hi_r);
  assign lo_b = lo_r[BIT_W-1:0];
  assign hi_b = hi_r[BIT_W-1:0];

  // Free bits of the returned word that fall inside the current range.
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      free_bits[j] = !mem_rdata[j]
                     && ((dw_r != lo_w) || (BIT_W'(j) >= lo_b))
                     && ((dw_r != hi_w) || (BIT_W'(j) <= hi_b));
    end
  end

  assign hit     = first_set(free_bits);
  assign found   = dv_r && hit[BIT_W];
  assign cur_bit = mem_rdata[tid_r[BIT_W-1:0]];

  assign spec_bad = (tid_r > top) || (tid_r <= cfg.reserved_top);
  assign kern_bad = (tid_r == '0) || (tid_r > cfg.reserved_top) || (tid_r > ID_MAX);
  assign free_bad = (tid_r <= cfg.reserved_top) || (tid_r > top);

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_HOLD);
  assign res       = res_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_cnt_r == LAST_WORD) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        unique case (op_r)
          OP_AUTO: state_nxt = S_RANGE;
          OP_SPEC: state_nxt = (tid_r == '0) ? S_RANGE : (spec_bad ? S_HOLD : S_RMW);
          OP_KERN: state_nxt = kern_bad ? S_HOLD : S_RMW;
          OP_FREE: state_nxt = ((tid_r == '0) || free_bad) ? S_HOLD : S_RMW;
        endcase
      end
      S_RMW:    state_nxt = S_HOLD;
      S_RANGE:  if (!rng_empty) begin
        state_nxt = S_SCAN;
      end else if (range2_r) begin
        state_nxt = S_HOLD;
      end
      S_SCAN: begin
        if (found) begin
          state_nxt = S_HOLD;
        end else if (dv_r && (dw_r == hi_w)) begin
          state_nxt = range2_r ? S_HOLD : S_RANGE;
        end
      end
      S_HOLD:   if (res_take) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory requests.
  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    op_nxt       = op_r;
    tid_nxt      = tid_r;
    range2_nxt   = range2_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    iss_w_nxt    = iss_w_r;
    iss_done_nxt = iss_done_r;
    dv_nxt       = 1'b0;
    dw_nxt       = dw_r;
    res_nxt      = res_r;
    mem_req      = '0;
    mem_req.addr = word_of(tid_r);

    unique case (state_r)
      S_CLEAR: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_cnt_r;
        mem_req.wdata = (clr_cnt_r == '0) ? WORD_BITS'(1) : '0;
        clr_cnt_nxt   = clr_cnt_r + 1'b1;
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = op_t'(in_op);
          tid_nxt    = in_tid;
          range2_nxt = 1'b0;
        end
      end
      S_DECODE: begin
        res_nxt.id     = '0;
        res_nxt.status = ST_OK;
        unique case (op_r)
          OP_AUTO: ;
          OP_SPEC: if (tid_r != '0) begin
            res_nxt.status = spec_bad ? ST_INVALID : ST_OK;
            mem_req.en     = !spec_bad;
          end
          OP_KERN: begin
            res_nxt.status = kern_bad ? ST_INVALID : ST_OK;
            mem_req.en     = !kern_bad;
          end
          OP_FREE: if (tid_r != '0) begin
            res_nxt.status = free_bad ? ST_REFUSED : ST_OK;
            mem_req.en     = !free_bad;
          end
        endcase
      end
      S_RMW: begin
        if (op_r == OP_FREE) begin
          if (!cur_bit) begin
            res_nxt.status = ST_REFUSED;
          end else begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.wdata = mem_rdata & ~(WORD_BITS'(1) << tid_r[BIT_W-1:0]);
          end
        end else if (cur_bit) begin
          res_nxt.status = ST_TAKEN;
        end else begin
          mem_req.en    = 1'b1;
          mem_req.we    = 1'b1;
          mem_req.wdata = mem_rdata | (WORD_BITS'(1) << tid_r[BIT_W-1:0]);
          res_nxt.id    = tid_r;
        end
      end
      S_RANGE: begin
        lo_nxt       = rng_lo;
        hi_nxt       = rng_hi;
        iss_w_nxt    = word_of(rng_lo);
        iss_done_nxt = 1'b0;
        if (rng_empty) begin
          if (range2_r) begin
            res_nxt.status = ST_TAKEN;
          end else begin
            range2_nxt = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          // Claim the lowest free bit of the word that just came back.
          mem_req.en     = 1'b1;
          mem_req.we     = 1'b1;
          mem_req.addr   = dw_r;
          mem_req.wdata  = mem_rdata | (WORD_BITS'(1) << hit[BIT_W-1:0]);
          res_nxt.status = ST_OK;
          res_nxt.id     = ID_W'({dw_r, hit[BIT_W-1:0]});
        end else if (dv_r && (dw_r == hi_w)) begin
          if (range2_r) begin
            res_nxt.status = ST_TAKEN;
          end else begin
            range2_nxt = 1'b1;
          end
        end else begin
          // Reads run one word ahead of the evaluation.
          mem_req.en   = !iss_done_r;
          mem_req.addr = iss_w_r;
          dv_nxt       = !iss_done_r;
          dw_nxt       = iss_w_r;
          if (!iss_done_r) begin
            if (iss_w_r == hi_w) begin
              iss_done_nxt = 1'b1;
            end else begin
              iss_w_nxt = iss_w_r + 1'b1;
            end
          end
        end
      end
      S_HOLD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_cnt_r  <= '0;
      dv_r       <= 1'b0;
      iss_done_r <= 1'b0;
      range2_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      dv_r       <= dv_nxt;
      iss_done_r <= iss_done_nxt;
      range2_r   <= range2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    tid_r   <= tid_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    iss_w_r <= iss_w_nxt;
    dw_r    <= dw_nxt;
    res_r   <= res_nxt;
  end

`ifndef SYNTHESIS
  a_grant_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.id != '0)) |-> (res.status == ST_OK))
    else $error("nonzero granted ID with a failing status");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CLEAR) && (clr_cnt_r == LAST_WORD)) |=> (state_r == S_IDLE))
    else $error("clearing pass did not end after the last word");

  a_scan_word_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && dv_r) |-> ((dw_r >= lo_w) && (dw_r <= hi_w)))
    else $error("scanned word outside the current range");

  a_scan_write_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && mem_req.we) |-> dv_r)
    else $error("scan wrote the bitmap without returned data");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("input accepted during the clearing pass");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/ranged_id_bitmap_allocator_unit.sv =====
// Specific, kernel and free requests pass from decode through the read-modify-write state
// to the result hold state; one refused on the arguments alone, or a free of ID zero, goes
// straight from decode to the hold state. Automatic allocation reads one bitmap word per
// cycle from the single RAM port while it scans each range in turn.
// One request at a time: the next input word is accepted once the staged result has moved
// into the output register. Reset (rst_n, synchronous, active low) restores the control and
// configuration registers; no input word is accepted during its bitmap RAM clearing pass.
// ============================================================================
// Ranged ID bitmap allocator
// Top level: configuration registers, output register and the bitmap engine.
// ============================================================================
`default_nettype none

module ranged_id_bitmap_allocator_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input word: [1:0] operation, [17:2] target_id, [23:18] zero.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [23:0]                     in_tdata,
  // Output word: [1:0] status, [17:2] granted_id, [23:18] zero.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [23:0]                          out_tdata,
  // Configuration write channel.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rida_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rida_pkg::ID_W-1:0]       cfg_data
);
  import rida_pkg::*;

  // Configuration registers. Writes are taken in any cycle; the user writes them
  // only while the block is idle.
  cfg_t cfg_r, cfg_nxt;

  // Output register, loaded from the engine's staged result.
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r, out_res_nxt;

  logic                 res_valid;
  logic                 res_take;
  result_t              res;
  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_RESERVED_TOP:  cfg_nxt.reserved_top  = cfg_data;
        REG_OVERFLOW_LOW:  cfg_nxt.overflow_low  = cfg_data;
        REG_OVERFLOW_HIGH: cfg_nxt.overflow_high = cfg_data;
        REG_USER_LOW:      cfg_nxt.user_low      = cfg_data;
        REG_ID_TOP:        cfg_nxt.id_top        = cfg_data;
        default: ;
      endcase
    end
  end

  // The staged result moves into the output register whenever that register is
  // empty or being drained this cycle.
  assign res_take = !out_valid_r || out_tready;

  always_comb begin
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (res_valid && res_take) begin
      out_res_nxt   = res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reserved_top  <= 16'd99;
      cfg_r.overflow_low  <= 16'd100;
      cfg_r.overflow_high <= 16'd999;
      cfg_r.user_low      <= 16'd1000;
      cfg_r.id_top        <= 16'd65535;
      out_valid_r         <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.id, out_res_r.status};

  rida_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tdata[1:0]),
    .in_tid    (in_tdata[17:2]),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  rida_map_mem u_map (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire
